[rtl/core/is_pkg.sv]
// Shared types and sizing constants for the insertion sorter.
// Used by insertion_sorter_unit and is_out_buf; no dependencies.
package is_pkg;

   // Store capacity and derived widths
   localparam int MAX_ELEMS = 64;
   localparam int ADDR_W    = $clog2(MAX_ELEMS);
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
   localparam int VAL_W     = 32;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_EMIT
   } state_type;

   // One result on its way to the output port
   typedef struct packed {
      logic signed [VAL_W-1:0] sorted_value;
      logic                    last_result;
      logic                    overflowed;
   } rsp_item_type;

endpackage

[rtl/core/is_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module is_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/is_out_buf.sv]
// Two-entry result buffer that decouples memory reads from the result port.
// Depends on is_pkg for the result item type.
module is_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  is_pkg::rsp_item_type push_item,
   input  logic                 pop,
   output logic                 not_empty,
   output logic [1:0]           count,
   output is_pkg::rsp_item_type head_item
);

   is_pkg::rsp_item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed result
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign count     = count_ff;
   assign head_item = entry_ff[rd_ptr_ff];

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != 2'd2)
      else $error("result buffer pushed while full");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result buffer count out of range");
   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push |=> not_empty)
      else $error("pushed result not visible");
`endif

endmodule

[rtl/core/insertion_sorter_unit.sv]
// Top level of the insertion sorter: sequencer, sorted store RAM, result buffer.
// Depends on is_pkg, is_ram and is_out_buf.
//
//   channel | ports      | tdata            | tlast       | tuser
//   --------+------------+------------------+-------------+-----------
//   input   | req_t*     | value [31:0]     | last_item   | -
//   result  | rsp_t*     | sorted_value     | last_result | overflowed
//
// An input item is written at once when the store is empty and dropped when
// it is full; otherwise each stored entry greater than the value is shifted
// up, one shift per cycle through the single write port of the store RAM.
// A marked item is followed by one RAM read per cycle, one result per cycle
// while rsp_tready stays high. Input is not taken during insertion or read-out.
// Reset is synchronous; the store needs no clearing pass.
module insertion_sorter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast,
   output logic        rsp_tuser    // [0] overflowed
);

   localparam int AW = is_pkg::ADDR_W;
   localparam int CW = is_pkg::CNT_W;
   localparam int VW = is_pkg::VAL_W;

   is_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 lost_ff, lost_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic signed [VW-1:0] val_ff, val_in;
   logic                 last_ff, last_in;
   logic [AW-1:0]        rd_k_ff, rd_k_in;
   logic                 infl_ff, infl_in;
   logic                 infl_last_ff, infl_last_in;
   logic                 infl_ovf_ff, infl_ovf_in;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [VW-1:0] ram_wr_data, ram_rd_data;

   logic                 accept, pop, emit_rd, emit_final;
   logic [1:0]           buf_count;
   logic                 buf_not_empty;
   logic [2:0]           used;
   is_pkg::rsp_item_type push_item, head_item;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   // Buffer slots taken once in-flight reads land, less the one leaving now
   assign used   = {1'b0, buf_count} + {2'b0, infl_ff} - {2'b0, pop};

   // Sequencer: insert by shifting larger entries up, then read out
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      lost_in     = lost_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      last_in     = last_ff;
      rd_k_in     = rd_k_ff;
      req_tready  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pos_ff;
      ram_wr_data = val_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pos_ff - AW'(1);
      emit_rd     = 1'b0;
      emit_final  = 1'b0;
      case (state_ff)
         is_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            rd_k_in    = '0;
            if (accept) begin
               val_in  = req_tdata;
               last_in = req_tlast;
               if (cnt_ff == CW'(is_pkg::MAX_ELEMS)) begin
                  // Store full: drop the value
                  lost_in  = 1'b1;
                  state_in = req_tlast ? is_pkg::ST_EMIT : is_pkg::ST_IDLE;
               end else if (cnt_ff == '0) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = '0;
                  ram_wr_data = req_tdata;
                  cnt_in      = CW'(1);
                  state_in    = req_tlast ? is_pkg::ST_EMIT : is_pkg::ST_IDLE;
               end else begin
                  // Fetch the top entry for the first compare
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = cnt_ff[AW-1:0] - AW'(1);
                  pos_in      = cnt_ff[AW-1:0];
                  state_in    = is_pkg::ST_SHIFT;
               end
            end
         end
         is_pkg::ST_SHIFT: begin
            ram_wr_en = 1'b1;
            if ($signed(ram_rd_data) > val_ff) begin
               // Move the larger entry up one place
               ram_wr_data = ram_rd_data;
               pos_in      = pos_ff - AW'(1);
               if (pos_ff == AW'(1)) begin
                  state_in = is_pkg::ST_PLACE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = pos_ff - AW'(2);
               end
            end else begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = last_ff ? is_pkg::ST_EMIT : is_pkg::ST_IDLE;
            end
         end
         is_pkg::ST_PLACE: begin
            ram_wr_en = 1'b1;
            cnt_in    = cnt_ff + CW'(1);
            state_in  = last_ff ? is_pkg::ST_EMIT : is_pkg::ST_IDLE;
         end
         is_pkg::ST_EMIT: begin
            ram_rd_addr = rd_k_ff;
            if (used < 3'd2) begin
               ram_rd_en = 1'b1;
               emit_rd   = 1'b1;
               rd_k_in   = rd_k_ff + AW'(1);
               if ({1'b0, rd_k_ff} + CW'(1) == cnt_ff) begin
                  // Final read: empty the store for the next set
                  emit_final = 1'b1;
                  cnt_in     = '0;
                  lost_in    = 1'b0;
                  state_in   = is_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = is_pkg::ST_IDLE;
         end
      endcase
      infl_in      = emit_rd;
      infl_last_in = emit_final;
      infl_ovf_in  = lost_ff;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= is_pkg::ST_IDLE;
         cnt_ff   <= '0;
         lost_ff  <= 1'b0;
         infl_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         lost_ff  <= lost_in;
         infl_ff  <= infl_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      last_ff      <= last_in;
      rd_k_ff      <= rd_k_in;
      infl_last_ff <= infl_last_in;
      infl_ovf_ff  <= infl_ovf_in;
   end

   is_ram #(
      .WIDTH (VW),
      .DEPTH (is_pkg::MAX_ELEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Land each read-out word in the result buffer
   always_comb begin
      push_item.sorted_value = ram_rd_data;
      push_item.last_result  = infl_last_ff;
      push_item.overflowed   = infl_ovf_ff;
   end

   is_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (infl_ff),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (buf_not_empty),
      .count     (buf_count),
      .head_item (head_item)
   );

   assign rsp_tvalid = buf_not_empty;
   assign rsp_tdata  = head_item.sorted_value;
   assign rsp_tlast  = head_item.last_result;
   assign rsp_tuser  = head_item.overflowed;

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(is_pkg::MAX_ELEMS))
      else $error("element count beyond capacity");
   a_shift_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == is_pkg::ST_SHIFT |-> pos_ff != '0)
      else $error("shift step with no entry below");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == is_pkg::ST_EMIT |-> cnt_ff != '0)
      else $error("read-out of an empty store");
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      emit_final |=> cnt_ff == '0 && !lost_ff && state_ff == is_pkg::ST_IDLE)
      else $error("store not emptied after read-out");
`endif

endmodule
